### hdl/spr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants for the shortest-path relaxation block
// Sizes of the edge and distance stores, field widths, opcodes, register
// indexes and the control bundle that drives the distance store.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int MAX_VERTICES  = 64;
  localparam int MAX_EDGES     = 256;
  localparam int WEIGHT_BITS   = 16;

  localparam int VID_BITS      = $clog2(MAX_VERTICES);
  localparam int EIDX_BITS     = $clog2(MAX_EDGES);
  localparam int VCNT_BITS     = 7;
  localparam int ECNT_BITS     = 9;
  localparam int CFG_BITS      = 9;

  // Internal distances stay wide enough for the longest walk a run can build,
  // even with a negative cycle feeding it.
  localparam int DIST_BITS     = 32;
  localparam int OUT_DIST_BITS = 22;

  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 32;

  // Request opcodes (tuser on the input side)
  localparam logic OP_EDGE_WRITE = 1'b0;
  localparam logic OP_RUN        = 1'b1;

  // Configuration register indexes
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_EDGE_COUNT   = 1'b1;

  typedef struct packed {
    logic [VID_BITS-1:0]           tail;
    logic [VID_BITS-1:0]           head;
    logic signed [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                        reach;
    logic signed [DIST_BITS-1:0] dist_val;
  } dist_entry_t;

  typedef struct packed {
    logic                        clear;
    logic [VID_BITS-1:0]         rd_a_addr;
    logic [VID_BITS-1:0]         rd_b_addr;
    logic                        wr_en;
    logic [VID_BITS-1:0]         wr_addr;
    logic signed [DIST_BITS-1:0] wr_data;
  } dist_ctrl_t;

endpackage

### hdl/spr_edge_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_edge_store: edge memory
// One write port for edge loads, one registered read port for the sequencer.
// ----------------------------------------------------------------------------
module spr_edge_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [spr_pkg::EIDX_BITS-1:0] wr_addr,
  input  spr_pkg::edge_t                wr_data,
  input  logic [spr_pkg::EIDX_BITS-1:0] rd_addr,
  output spr_pkg::edge_t                rd_data
);

  spr_pkg::edge_t mem [spr_pkg::MAX_EDGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/spr_dist_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_dist_store: per-vertex distance memory with reachable flags
// Two registered read ports, one write port. Reachable flags sit in
// flip-flops so a run can clear them all at once.
// ----------------------------------------------------------------------------
module spr_dist_store (
  input  logic                 clk,
  input  logic                 rst,
  input  spr_pkg::dist_ctrl_t  ctrl,
  output spr_pkg::dist_entry_t rd_a,
  output spr_pkg::dist_entry_t rd_b
);

  logic [spr_pkg::MAX_VERTICES-1:0]  reach;
  logic signed [spr_pkg::DIST_BITS-1:0] dist_mem [spr_pkg::MAX_VERTICES];

  // A clear drops every flag and marks the seeded vertex in the same step
  always_ff @(posedge clk) begin
    if (rst) begin
      reach <= '0;
    end else if (ctrl.clear) begin
      reach <= {{(spr_pkg::MAX_VERTICES-1){1'b0}}, ctrl.wr_en} << ctrl.wr_addr;
    end else if (ctrl.wr_en) begin
      reach[ctrl.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      dist_mem[ctrl.wr_addr] <= ctrl.wr_data;
    end
    rd_a.reach    <= reach[ctrl.rd_a_addr];
    rd_a.dist_val <= dist_mem[ctrl.rd_a_addr];
    rd_b.reach    <= reach[ctrl.rd_b_addr];
    rd_b.dist_val <= dist_mem[ctrl.rd_b_addr];
  end

endmodule

### hdl/spr_relax_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_relax_unit: shared add and compare for one edge
// Forms the candidate distance through the edge and decides whether it
// lowers the head's distance.
// ----------------------------------------------------------------------------
module spr_relax_unit (
  input  spr_pkg::edge_t                  edge_in,
  input  logic [spr_pkg::VCNT_BITS-1:0]   nv,
  input  spr_pkg::dist_entry_t            tail_e,
  input  spr_pkg::dist_entry_t            head_e,
  output logic signed [spr_pkg::DIST_BITS-1:0] cand,
  output logic                            relax
);

  logic                                 in_range;
  logic signed [spr_pkg::DIST_BITS-1:0] weight_ext;

  assign in_range = (spr_pkg::VCNT_BITS'(edge_in.tail) < nv) &&
                    (spr_pkg::VCNT_BITS'(edge_in.head) < nv);

  assign weight_ext = {{(spr_pkg::DIST_BITS - spr_pkg::WEIGHT_BITS)
                        {edge_in.weight[spr_pkg::WEIGHT_BITS-1]}}, edge_in.weight};

  assign cand  = tail_e.dist_val + weight_ext;
  assign relax = in_range && tail_e.reach &&
                 (!head_e.reach || (cand < head_e.dist_val));

endmodule

### hdl/shortest_path_relaxation.sv
`timescale 1ns / 1ps
// An edge write keeps the sequencer idle; the block is ready again the next cycle.
// A run clears and seeds the source, then makes the relaxation passes and a checking pass
// over the edges in use, each edge going through edge read, distance read and add/compare/write,
// then sends each vertex result while the output is not stalled, or stops at a negative cycle.
// Throughput: one request at a time; input is not ready during a run.
// Reset: vertex_count 1, edge_count 0, idle, reach flags cleared; edges and distances kept.
// ----------------------------------------------------------------------------
// shortest_path_relaxation: Bellman-Ford single-source shortest paths
// Edges load into an edge store by slot. A run request relaxes the first
// edge_count edges vertex_count-1 times with one shared relax unit, checks
// for a negative cycle with one more pass, and streams out the results.
// ----------------------------------------------------------------------------
module shortest_path_relaxation (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [spr_pkg::CFG_BITS-1:0]      cfg_data,
  // Request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: edge_index[7:0], edge_from[13:8], edge_to[19:14],
  //   edge_weight[35:20], source_vertex[41:36], zero pad[47:42]
  input  logic [spr_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // tuser: opcode
  input  logic                              s_axis_tuser,
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: vertex_id[5:0], distance[27:6], reachable[28],
  //   negative_cycle[29], zero pad[31:30]
  output logic [spr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                              m_axis_tlast
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_DIST   = 3'd3;
  localparam logic [2:0] S_EVAL   = 3'd4;
  localparam logic [2:0] S_OUT_RD = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;
  localparam logic [2:0] S_NEG    = 3'd7;

  localparam int PAD_BITS = spr_pkg::OUT_DATA_BITS - spr_pkg::VID_BITS
                            - spr_pkg::OUT_DIST_BITS - 2;

  logic [2:0]                       state;
  logic [2:0]                       state_next;
  logic [spr_pkg::VCNT_BITS-1:0]    vertex_count;
  logic [spr_pkg::ECNT_BITS-1:0]    edge_count;
  logic [spr_pkg::VID_BITS-1:0]     src;
  logic [spr_pkg::ECNT_BITS-1:0]    j;
  logic [spr_pkg::VCNT_BITS-1:0]    pass;
  logic [spr_pkg::VID_BITS-1:0]     v;

  logic [spr_pkg::VCNT_BITS-1:0]    nv;
  logic [spr_pkg::ECNT_BITS-1:0]    ne;
  logic [spr_pkg::ECNT_BITS-1:0]    j_inc;
  logic                             check;
  logic                             src_ok;
  logic                             last_v;
  logic                             in_accept;
  logic                             edge_wr;

  spr_pkg::edge_t                   edge_wr_data;
  spr_pkg::edge_t                   edge_q;
  spr_pkg::dist_ctrl_t              dctrl;
  spr_pkg::dist_entry_t             rd_a;
  spr_pkg::dist_entry_t             rd_b;
  logic signed [spr_pkg::DIST_BITS-1:0] cand;
  logic                             relax;
  logic [spr_pkg::OUT_DIST_BITS-1:0] dist_out;

  // Saturate the configured counts into the ranges the stores support
  always_comb begin
    if (vertex_count == '0) begin
      nv = spr_pkg::VCNT_BITS'(1);
    end else if (vertex_count > spr_pkg::VCNT_BITS'(spr_pkg::MAX_VERTICES)) begin
      nv = spr_pkg::VCNT_BITS'(spr_pkg::MAX_VERTICES);
    end else begin
      nv = vertex_count;
    end
    if (edge_count > spr_pkg::ECNT_BITS'(spr_pkg::MAX_EDGES)) begin
      ne = spr_pkg::ECNT_BITS'(spr_pkg::MAX_EDGES);
    end else begin
      ne = edge_count;
    end
  end

  assign j_inc  = j + spr_pkg::ECNT_BITS'(1);
  // The pass after the last relaxation pass only looks for a negative cycle
  assign check  = (pass == nv);
  assign src_ok = spr_pkg::VCNT_BITS'(src) < nv;
  assign last_v = (spr_pkg::VCNT_BITS'(v) + spr_pkg::VCNT_BITS'(1)) == nv;

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign edge_wr       = in_accept && (s_axis_tuser == spr_pkg::OP_EDGE_WRITE);

  assign edge_wr_data.tail   = s_axis_tdata[13:8];
  assign edge_wr_data.head   = s_axis_tdata[19:14];
  assign edge_wr_data.weight = s_axis_tdata[35:20];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= spr_pkg::VCNT_BITS'(1);
      edge_count   <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == spr_pkg::REG_VERTEX_COUNT) begin
        vertex_count <= cfg_data[spr_pkg::VCNT_BITS-1:0];
      end else begin
        edge_count <= cfg_data[spr_pkg::ECNT_BITS-1:0];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && (s_axis_tuser == spr_pkg::OP_RUN)) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        // No edges: nothing to relax or check, go straight to results
        state_next = (ne == '0) ? S_OUT_RD : S_FETCH;
      end
      S_FETCH: state_next = S_DIST;
      S_DIST:  state_next = S_EVAL;
      S_EVAL: begin
        if (check && relax) begin
          state_next = S_NEG;
        end else if (j_inc == ne) begin
          state_next = check ? S_OUT_RD : S_FETCH;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_OUT_RD: state_next = S_OUT;
      S_OUT: begin
        if (m_axis_tready) begin
          state_next = last_v ? S_IDLE : S_OUT_RD;
        end
      end
      S_NEG: begin
        if (m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Loop counters: edge index, pass number, output vertex
  always_ff @(posedge clk) begin
    if (in_accept) begin
      src <= s_axis_tdata[41:36];
    end
    unique case (state)
      S_INIT: begin
        j    <= '0;
        pass <= spr_pkg::VCNT_BITS'(1);
        v    <= '0;
      end
      S_EVAL: begin
        if (j_inc == ne) begin
          j    <= '0;
          pass <= pass + spr_pkg::VCNT_BITS'(1);
          v    <= '0;
        end else begin
          j <= j_inc;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          v <= v + spr_pkg::VID_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  spr_edge_store u_edge_store (
    .clk     (clk),
    .wr_en   (edge_wr),
    .wr_addr (s_axis_tdata[spr_pkg::EIDX_BITS-1:0]),
    .wr_data (edge_wr_data),
    .rd_addr (j[spr_pkg::EIDX_BITS-1:0]),
    .rd_data (edge_q)
  );

  // Distance store control: clear and seed the source at run start, read the
  // edge's endpoints, write back a relaxed head, hold port A on the output vertex
  always_comb begin
    dctrl.clear     = (state == S_INIT);
    dctrl.rd_a_addr = ((state == S_OUT_RD) || (state == S_OUT)) ? v : edge_q.tail;
    dctrl.rd_b_addr = edge_q.head;
    dctrl.wr_en     = 1'b0;
    dctrl.wr_addr   = edge_q.head;
    dctrl.wr_data   = cand;
    if (state == S_INIT) begin
      dctrl.wr_en   = src_ok;
      dctrl.wr_addr = src;
      dctrl.wr_data = '0;
    end else if (state == S_EVAL) begin
      dctrl.wr_en   = relax && !check;
    end
  end

  spr_dist_store u_dist_store (
    .clk  (clk),
    .rst  (rst),
    .ctrl (dctrl),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  spr_relax_unit u_relax_unit (
    .edge_in (edge_q),
    .nv      (nv),
    .tail_e  (rd_a),
    .head_e  (rd_b),
    .cand    (cand),
    .relax   (relax)
  );

  // Result stream: a vertex result from port A, or the negative-cycle flag
  assign dist_out      = rd_a.reach ? rd_a.dist_val[spr_pkg::OUT_DIST_BITS-1:0] : '0;
  assign m_axis_tvalid = (state == S_OUT) || (state == S_NEG);
  assign m_axis_tlast  = (state == S_NEG) || last_v;

  always_comb begin
    if (state == S_NEG) begin
      m_axis_tdata = {{PAD_BITS{1'b0}}, 1'b1, 1'b0,
                      {spr_pkg::OUT_DIST_BITS{1'b0}}, {spr_pkg::VID_BITS{1'b0}}};
    end else begin
      m_axis_tdata = {{PAD_BITS{1'b0}}, 1'b0, rd_a.reach, dist_out, v};
    end
  end

endmodule

### hdl/spr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_checker: port-level checks for shortest_path_relaxation
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module spr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [spr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                              m_axis_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("result changed while stalled");

  // The block never takes a request while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request accepted during result delivery");

  // A negative-cycle result stands alone and carries nothing else
  a_neg_alone: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[29]) |->
      (m_axis_tlast && (m_axis_tdata[28:0] == 29'd0)))
    else $error("malformed negative-cycle result");

  // Unreachable vertices report zero distance
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[28]) |-> (m_axis_tdata[27:6] == 22'd0))
    else $error("unreachable vertex with nonzero distance");

  // Ready for requests right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> (s_axis_tready && !m_axis_tvalid))
    else $error("not idle after reset");

endmodule

bind shortest_path_relaxation spr_checker u_spr_checker (.*);

### verif/shortest_path_relaxation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_path_relaxation_tb: self-checking bench for the shortest-path block
// Loads edge lists, mostly small, and runs from chosen sources. A directed table
// hits the corner cases; random graphs follow. Every result on the output stream
// is checked field by field against the table or a local Bellman-Ford predictor.
// ----------------------------------------------------------------------------
module shortest_path_relaxation_tb;
  import spr_pkg::*;

  localparam int ITEM_TARGET   = 470;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 50;
  // Longest silent stretch is one full run over the largest graph
  localparam int STALL_LIMIT   = 200000;

  typedef struct packed {
    bit [VID_BITS-1:0]             vertex_id;
    bit signed [OUT_DIST_BITS-1:0] distance;
    bit                            reachable;
    bit                            negative_cycle;
    bit                            last;
  } path_result_t;

  typedef enum bit [1:0] {ROW_SET_VCOUNT, ROW_SET_ECOUNT, ROW_EDGE, ROW_RUN} row_kind_e;

  // arg: register value, edge slot or run source, depending on kind
  typedef struct packed {
    row_kind_e               kind;
    bit [CFG_BITS-1:0]       arg;
    bit [VID_BITS-1:0]       from_v;
    bit [VID_BITS-1:0]       to_v;
    bit signed [WEIGHT_BITS-1:0] weight;
    bit                      typed;
    path_result_t            want;
  } dir_row_t;

  localparam path_result_t SOURCE_ONLY = '{6'd0, 22'sd0, 1'b1, 1'b0, 1'b1};
  localparam path_result_t UNREACHED   = '{6'd0, 22'sd0, 1'b0, 1'b0, 1'b1};
  localparam path_result_t NEG_CYCLE   = '{6'd0, 22'sd0, 1'b0, 1'b1, 1'b1};
  localparam path_result_t NO_WANT     = '0;

  localparam dir_row_t DIRECTED_ROWS [24] = '{
    // reset config: one vertex, no edges
    '{ROW_RUN,        9'd0,   6'd0,  6'd0,  16'sd0,     1'b1, SOURCE_ONLY},
    '{ROW_RUN,        9'd63,  6'd0,  6'd0,  16'sd0,     1'b1, UNREACHED},
    // vertex count zero behaves as one
    '{ROW_SET_VCOUNT, 9'd0,   6'd0,  6'd0,  16'sd0,     1'b0, NO_WANT},
    '{ROW_RUN,        9'd0,   6'd0,  6'd0,  16'sd0,     1'b1, SOURCE_ONLY},
    // single negative self loop on the only vertex
    '{ROW_SET_ECOUNT, 9'd1,   6'd0,  6'd0,  16'sd0,     1'b0, NO_WANT},
    '{ROW_EDGE,       9'd0,   6'd0,  6'd0,  -16'sd1,    1'b0, NO_WANT},
    '{ROW_RUN,        9'd0,   6'd0,  6'd0,  16'sd0,     1'b1, NEG_CYCLE},
    '{ROW_EDGE,       9'd0,   6'd0,  6'd0,  16'sd32767, 1'b0, NO_WANT},
    '{ROW_RUN,        9'd0,   6'd0,  6'd0,  16'sd0,     1'b1, SOURCE_ONLY},
    // four-vertex chain with extreme weights and an out-of-range head
    '{ROW_SET_VCOUNT, 9'd4,   6'd0,  6'd0,  16'sd0,     1'b0, NO_WANT},
    '{ROW_SET_ECOUNT, 9'd5,   6'd0,  6'd0,  16'sd0,     1'b0, NO_WANT},
    '{ROW_EDGE,       9'd0,   6'd0,  6'd1,  16'sd32767, 1'b0, NO_WANT},
    '{ROW_EDGE,       9'd1,   6'd1,  6'd2,  -16'sd32768, 1'b0, NO_WANT},
    '{ROW_EDGE,       9'd2,   6'd2,  6'd3,  16'sd5,     1'b0, NO_WANT},
    '{ROW_EDGE,       9'd3,   6'd3,  6'd63, -16'sd7,    1'b0, NO_WANT},
    '{ROW_EDGE,       9'd4,   6'd3,  6'd0,  16'sd0,     1'b0, NO_WANT},
    '{ROW_RUN,        9'd0,   6'd0,  6'd0,  16'sd0,     1'b0, NO_WANT},
    '{ROW_RUN,        9'd2,   6'd0,  6'd0,  16'sd0,     1'b0, NO_WANT},
    '{ROW_RUN,        9'd4,   6'd0,  6'd0,  16'sd0,     1'b0, NO_WANT},
    // top slot, outside the edges in use
    '{ROW_EDGE,       9'd255, 6'd63, 6'd63, -16'sd32768, 1'b0, NO_WANT},
    // close a negative loop 1 -> 2 -> 1
    '{ROW_EDGE,       9'd4,   6'd2,  6'd1,  16'sd32760, 1'b0, NO_WANT},
    '{ROW_RUN,        9'd0,   6'd0,  6'd0,  16'sd0,     1'b0, NO_WANT},
    '{ROW_RUN,        9'd63,  6'd0,  6'd0,  16'sd0,     1'b0, NO_WANT},
    '{ROW_RUN,        9'd3,   6'd0,  6'd0,  16'sd0,     1'b0, NO_WANT}
  };

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     cfg_wr_en     = 1'b0;
  logic                     cfg_index     = REG_VERTEX_COUNT;
  logic [CFG_BITS-1:0]      cfg_data      = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     s_axis_tuser  = OP_EDGE_WRITE;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tlast;

  shortest_path_relaxation u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Mirror of the block's registers and edge store
  bit [VCNT_BITS-1:0] vertex_count_cfg = 7'd1;
  bit [ECNT_BITS-1:0] edge_count_cfg   = 9'd0;
  bit [VID_BITS-1:0]  edge_tail [MAX_EDGES];
  bit [VID_BITS-1:0]  edge_head [MAX_EDGES];
  int                 edge_wt   [MAX_EDGES];
  longint             path_dist  [MAX_VERTICES];
  bit                 path_reach [MAX_VERTICES];

  path_result_t expected_paths [$];
  int           error_count     = 0;
  int           requests_taken  = 0;
  int           src_idle_pct    = 20;
  int           sink_idle_pct   = 20;
  int           stall_cycles    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // True when edge j would still lower its head's distance; cand gets the sum.
  function automatic bit edge_lowers_head(int j, int nv, output longint cand);
    cand = 0;
    if (edge_tail[j] >= nv || edge_head[j] >= nv) return 1'b0;
    if (!path_reach[edge_tail[j]]) return 1'b0;
    cand = path_dist[edge_tail[j]] + edge_wt[j];
    return !path_reach[edge_head[j]] || cand < path_dist[edge_head[j]];
  endfunction

  // Bellman-Ford from src over the edges in use; queue the results it yields.
  function automatic void solve_from(bit [VID_BITS-1:0] src);
    int           nv;
    int           ne;
    longint       cand;
    path_result_t res;
    nv = (vertex_count_cfg == 0) ? 1 :
         (vertex_count_cfg > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_cfg);
    ne = (edge_count_cfg > MAX_EDGES) ? MAX_EDGES : int'(edge_count_cfg);
    foreach (path_dist[v]) begin
      path_dist[v]  = 0;
      path_reach[v] = 1'b0;
    end
    if (src < nv) path_reach[src] = 1'b1;
    for (int p = 1; p < nv; p++) begin
      for (int j = 0; j < ne; j++) begin
        if (edge_lowers_head(j, nv, cand)) begin
          path_dist[edge_head[j]]  = cand;
          path_reach[edge_head[j]] = 1'b1;
        end
      end
    end
    // One more pass: anything still relaxing means a reachable negative cycle
    for (int j = 0; j < ne; j++) begin
      if (edge_lowers_head(j, nv, cand)) begin
        expected_paths.push_back(NEG_CYCLE);
        return;
      end
    end
    for (int v = 0; v < nv; v++) begin
      res.vertex_id      = VID_BITS'(v);
      res.distance       = path_reach[v] ? OUT_DIST_BITS'(path_dist[v]) : '0;
      res.reachable      = path_reach[v];
      res.negative_cycle = 1'b0;
      res.last           = (v + 1 == nv);
      expected_paths.push_back(res);
    end
  endfunction

  // Present one request, hold it until taken, then update the predictor.
  task automatic send_request(input logic op, input bit [EIDX_BITS-1:0] idx,
                              input bit [VID_BITS-1:0] from_v, input bit [VID_BITS-1:0] to_v,
                              input bit signed [WEIGHT_BITS-1:0] w,
                              input bit [VID_BITS-1:0] src, input bit typed,
                              input path_result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, src, w, to_v, from_v, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_taken++;
    if (op == OP_EDGE_WRITE) begin
      edge_tail[idx] = from_v;
      edge_head[idx] = to_v;
      edge_wt[idx]   = int'(w);
    end else if (typed) begin
      expected_paths.push_back(want);
    end else begin
      solve_from(src);
    end
  endtask

  task automatic write_edge(input bit [EIDX_BITS-1:0] idx, input bit [VID_BITS-1:0] from_v,
                            input bit [VID_BITS-1:0] to_v,
                            input bit signed [WEIGHT_BITS-1:0] w);
    send_request(OP_EDGE_WRITE, idx, from_v, to_v, w, VID_BITS'($urandom), 1'b0, NO_WANT);
  endtask

  // Unused fields of a run carry random bits; the block must ignore them.
  task automatic run_from(input bit [VID_BITS-1:0] src, input bit typed,
                          input path_result_t want);
    send_request(OP_RUN, EIDX_BITS'($urandom), VID_BITS'($urandom), VID_BITS'($urandom),
                 WEIGHT_BITS'($urandom), src, typed, want);
  endtask

  // Drop the request, drain every pending result, let the block settle,
  // then write the register.
  task automatic write_register(input logic idx, input bit [CFG_BITS-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_paths.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_VERTEX_COUNT) vertex_count_cfg = value[VCNT_BITS-1:0];
    else edge_count_cfg = value[ECNT_BITS-1:0];
  endtask

  // Mostly a vertex in use, now and then any vertex at all
  function automatic bit [VID_BITS-1:0] pick_vertex(int nv);
    return ($urandom_range(9) == 0) ? VID_BITS'($urandom) : VID_BITS'($urandom_range(nv - 1));
  endfunction

  // 0: small non-negative, 1: mostly positive with a few negatives, 2: anything
  function automatic bit signed [WEIGHT_BITS-1:0] pick_weight(int mode);
    case (mode)
      0:       return WEIGHT_BITS'($urandom_range(2000));
      1:       return WEIGHT_BITS'(int'($urandom_range(600)) - 100);
      default: return WEIGHT_BITS'($urandom);
    endcase
  endfunction

  function automatic void compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Result side: random back-pressure, check each taken result in order
  always @(posedge clk) begin : result_check
    path_result_t want;
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_paths.size() == 0) begin
        $error("result with nothing expected: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = expected_paths.pop_front();
        compare_field("vertex_id", want.vertex_id, m_axis_tdata[5:0]);
        compare_field("distance", want.distance, $signed(m_axis_tdata[27:6]));
        compare_field("reachable", want.reachable, m_axis_tdata[28]);
        compare_field("negative_cycle", want.negative_cycle, m_axis_tdata[29]);
        compare_field("last", want.last, m_axis_tlast);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int nv_raw;
    int nv_eff;
    int ne;
    int mode;
    int runs;
    foreach (edge_wt[j]) begin
      edge_tail[j] = '0;
      edge_head[j] = '0;
      edge_wt[j]   = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corner cases
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      case (DIRECTED_ROWS[i].kind)
        ROW_SET_VCOUNT: write_register(REG_VERTEX_COUNT, DIRECTED_ROWS[i].arg);
        ROW_SET_ECOUNT: write_register(REG_EDGE_COUNT, DIRECTED_ROWS[i].arg);
        ROW_EDGE:       write_edge(DIRECTED_ROWS[i].arg[EIDX_BITS-1:0],
                                   DIRECTED_ROWS[i].from_v, DIRECTED_ROWS[i].to_v,
                                   DIRECTED_ROWS[i].weight);
        default:        run_from(DIRECTED_ROWS[i].arg[VID_BITS-1:0],
                                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      endcase
    end

    // Random graphs: load a fresh edge list, then run it from a few sources
    for (phase = 0; requests_taken < ITEM_TARGET; phase++) begin
      // A stretch with no idling on either side
      src_idle_pct  = (phase >= 4 && phase < 8) ? 0 : 20;
      sink_idle_pct = src_idle_pct;
      if (phase == 2) begin
        // Largest graph once: both registers written past their limits
        write_register(REG_VERTEX_COUNT, 9'h1FF);
        write_register(REG_EDGE_COUNT, 9'h1FF);
        for (int j = 0; j < MAX_EDGES; j++) begin
          write_edge(EIDX_BITS'(j), VID_BITS'($urandom), VID_BITS'($urandom), pick_weight(0));
        end
        run_from(pick_vertex(MAX_VERTICES), 1'b0, NO_WANT);
        run_from(pick_vertex(MAX_VERTICES), 1'b0, NO_WANT);
        write_edge(EIDX_BITS'($urandom), VID_BITS'($urandom), VID_BITS'($urandom),
                   pick_weight(2));
        write_register(REG_VERTEX_COUNT, 9'd64);
        write_register(REG_EDGE_COUNT, 9'd256);
        run_from(pick_vertex(MAX_VERTICES), 1'b0, NO_WANT);
      end else begin
        case ($urandom_range(7))
          0:       nv_raw = 0;
          1:       nv_raw = $urandom_range(64, 127);
          default: nv_raw = $urandom_range(1, 10);
        endcase
        nv_eff = (nv_raw == 0) ? 1 : (nv_raw > MAX_VERTICES) ? MAX_VERTICES : nv_raw;
        ne     = $urandom_range(16);
        mode   = $urandom_range(2);
        // Upper data bits are outside the vertex count and must be ignored
        write_register(REG_VERTEX_COUNT, {2'($urandom), 7'(nv_raw)});
        write_register(REG_EDGE_COUNT, 9'(ne));
        for (int j = 0; j < ne; j++) begin
          write_edge(EIDX_BITS'(j), pick_vertex(nv_eff), pick_vertex(nv_eff),
                     pick_weight(mode));
        end
        runs = $urandom_range(1, 3);
        for (int r = 0; r < runs; r++) begin
          run_from(pick_vertex(nv_eff), 1'b0, NO_WANT);
          // Now and then overwrite a slot, used or not
          if ($urandom_range(1) == 0) begin
            write_edge(EIDX_BITS'($urandom), pick_vertex(nv_eff), pick_vertex(nv_eff),
                       pick_weight(mode));
          end
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_paths.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
hdl/spr_pkg.sv
hdl/spr_edge_store.sv
hdl/spr_dist_store.sv
hdl/spr_relax_unit.sv
hdl/shortest_path_relaxation.sv
hdl/spr_checker.sv
verif/shortest_path_relaxation_tb.sv
